// ===== rtl/core/ted_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_pkg
// Shared constants and types of the tide extremum detector.
// ----------------------------------------------------------------------------
package ted_pkg;

   // default field widths
   localparam int TIME_WIDTH_DEF   = 40;
   localparam int HEIGHT_WIDTH_DEF = 32;

   // fraction bits of the interpolation offset, and quotient bits per stage
   localparam int OFS_FRAC  = 16;
   localparam int DIV_STEPS = 2;

   // event kinds
   localparam logic KIND_HIGH = 1'b0;
   localparam logic KIND_LOW  = 1'b1;

   // per-event control flags travelling with the data
   typedef struct packed {
      logic kind;      // KIND_HIGH or KIND_LOW
      logic refine;    // equal steps and nonzero denominator
      logic sign_x;    // sign(diff) xor sign(den)
      logic diff_neg;  // older - newest < 0
      logic step_neg;  // time step negative
   } ted_flags_type;

endpackage

// ===== rtl/core/ted_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_window
// Sample window and classification: holds the two previous samples, tests
// the middle one for a high or low and prepares divider operands.
// ----------------------------------------------------------------------------
module ted_window import ted_pkg::*; #(
   parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
   parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [TIME_WIDTH-1:0]          in_time,
   input  logic signed [HEIGHT_WIDTH-1:0] in_height,
   input  logic                           in_start,
   output logic                           out_valid,
   input  logic                           out_ready,
   output ted_flags_type                  out_flags,
   output logic [HEIGHT_WIDTH:0]          out_num,
   output logic [HEIGHT_WIDTH+2:0]        out_dd,
   output logic [TIME_WIDTH-1:0]          out_smag,
   output logic signed [HEIGHT_WIDTH-1:0] out_mid,
   output logic [TIME_WIDTH-1:0]          out_mid_time
);

   localparam int TW = TIME_WIDTH;
   localparam int HW = HEIGHT_WIDTH;
   localparam logic [1:0] FILL_FULL = 2'd2;

   // window
   logic signed [HW-1:0] older_h_ff, mid_h_ff;
   logic [TW-1:0]        older_t_ff, mid_t_ff;
   logic [1:0]           fill_ff, fill_in, fill_eff;
   logic                 accept, full;

   // stage 0: captured triple
   logic                 v0_ff, en0;
   logic signed [HW-1:0] b0_ff, m0_ff, a0_ff;
   logic [TW-1:0]        to0_ff, tm0_ff, tn0_ff;

   // stage 1: compare and differences
   logic                 v1_ff, en1;
   logic                 kind1_ff;
   logic signed [HW+1:0] den1_ff, den_c;
   logic signed [HW:0]   diff1_ff, diff_c;
   logic [TW-1:0]        s1_1_ff, s2_1_ff;
   logic signed [HW-1:0] m1_ff;
   logic [TW-1:0]        tm1_ff;
   logic                 high_c, low_c;

   // stage 2: magnitudes and flags
   logic                 v2_ff, en2;
   ted_flags_type        flags2_ff, flags_c;
   logic [HW:0]          num2_ff, num_c;
   logic [HW+2:0]        dd2_ff, dd_c;
   logic [HW+1:0]        den_mag;
   logic [TW-1:0]        smag2_ff, smag_c;
   logic signed [HW-1:0] m2_ff;
   logic [TW-1:0]        tm2_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign en0      = !v0_ff || en1;
   assign in_ready = en0;
   assign accept   = in_valid && en0;

   // curve start empties the window before this sample is considered
   assign fill_eff = in_start ? '0 : fill_ff;
   assign full     = (fill_eff == FILL_FULL);
   assign fill_in  = full ? FILL_FULL : fill_eff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (fill_eff != '0) begin
            older_h_ff <= mid_h_ff;
            older_t_ff <= mid_t_ff;
         end
         mid_h_ff <= in_height;
         mid_t_ff <= in_time;
      end
   end

   // stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en0) begin
         v0_ff <= accept && full;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         b0_ff  <= older_h_ff;
         m0_ff  <= mid_h_ff;
         a0_ff  <= in_height;
         to0_ff <= older_t_ff;
         tm0_ff <= mid_t_ff;
         tn0_ff <= in_time;
      end
   end

   // stage 1
   always_comb begin
      high_c = (m0_ff > b0_ff) && (m0_ff >= a0_ff);
      low_c  = (m0_ff < b0_ff) && (m0_ff <= a0_ff);
      den_c  = {{2{b0_ff[HW-1]}}, b0_ff} - {m0_ff[HW-1], m0_ff, 1'b0}
             + {{2{a0_ff[HW-1]}}, a0_ff};
      diff_c = {b0_ff[HW-1], b0_ff} - {a0_ff[HW-1], a0_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= v0_ff && (high_c || low_c);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         kind1_ff <= low_c ? KIND_LOW : KIND_HIGH;
         den1_ff  <= den_c;
         diff1_ff <= diff_c;
         s1_1_ff  <= tm0_ff - to0_ff;
         s2_1_ff  <= tn0_ff - tm0_ff;
         m1_ff    <= m0_ff;
         tm1_ff   <= tm0_ff;
      end
   end

   // stage 2
   always_comb begin
      num_c   = $unsigned(diff1_ff[HW] ? -diff1_ff : diff1_ff);
      den_mag = $unsigned(den1_ff[HW+1] ? -den1_ff : den1_ff);
      dd_c    = {1'b0, den_mag[HW:0], 1'b0};
      smag_c  = s1_1_ff[TW-1] ? (~s1_1_ff + 1'b1) : s1_1_ff;
      flags_c.kind     = kind1_ff;
      flags_c.refine   = (s1_1_ff == s2_1_ff) && (den1_ff != '0);
      flags_c.sign_x   = diff1_ff[HW] ^ den1_ff[HW+1];
      flags_c.diff_neg = diff1_ff[HW];
      flags_c.step_neg = s1_1_ff[TW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         flags2_ff <= flags_c;
         num2_ff   <= num_c;
         dd2_ff    <= dd_c;
         smag2_ff  <= smag_c;
         m2_ff     <= m1_ff;
         tm2_ff    <= tm1_ff;
      end
   end

   assign out_valid    = v2_ff;
   assign out_flags    = flags2_ff;
   assign out_num      = num2_ff;
   assign out_dd       = dd2_ff;
   assign out_smag     = smag2_ff;
   assign out_mid      = m2_ff;
   assign out_mid_time = tm2_ff;

endmodule

// ===== rtl/core/ted_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_divider
// Pipelined restoring divider: floor(num * 2^OFS_FRAC / dd), DIV_STEPS
// quotient bits per stage, with the event payload carried alongside.
// ----------------------------------------------------------------------------
module ted_divider import ted_pkg::*; #(
   parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
   parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  ted_flags_type                  in_flags,
   input  logic [HEIGHT_WIDTH:0]          in_num,
   input  logic [HEIGHT_WIDTH+2:0]        in_dd,
   input  logic [TIME_WIDTH-1:0]          in_smag,
   input  logic signed [HEIGHT_WIDTH-1:0] in_mid,
   input  logic [TIME_WIDTH-1:0]          in_mid_time,
   output logic                           out_valid,
   input  logic                           out_ready,
   output ted_flags_type                  out_flags,
   output logic [OFS_FRAC-1:0]            out_q,
   output logic                           out_ge,
   output logic [HEIGHT_WIDTH:0]          out_num,
   output logic [TIME_WIDTH-1:0]          out_smag,
   output logic signed [HEIGHT_WIDTH-1:0] out_mid,
   output logic [TIME_WIDTH-1:0]          out_mid_time
);

   localparam int TW     = TIME_WIDTH;
   localparam int HW     = HEIGHT_WIDTH;
   localparam int RW     = HEIGHT_WIDTH + 3;
   localparam int STAGES = OFS_FRAC / DIV_STEPS;

   logic                 v_ff     [STAGES];
   logic                 en       [STAGES];
   logic [RW-1:0]        r_ff     [STAGES];
   logic [OFS_FRAC-1:0]  q_ff     [STAGES];
   logic [RW-1:0]        dd_ff    [STAGES];
   logic                 ge_ff    [STAGES];
   ted_flags_type        flags_ff [STAGES];
   logic [HW:0]          num_ff   [STAGES];
   logic [TW-1:0]        smag_ff  [STAGES];
   logic signed [HW-1:0] mid_ff   [STAGES];
   logic [TW-1:0]        midt_ff  [STAGES];

   // stage inputs
   logic                 src_v     [STAGES];
   logic [RW-1:0]        src_r     [STAGES];
   logic [OFS_FRAC-1:0]  src_q     [STAGES];
   logic [RW-1:0]        src_dd    [STAGES];
   ted_flags_type        src_flags [STAGES];
   logic [HW:0]          src_num   [STAGES];
   logic [TW-1:0]        src_smag  [STAGES];
   logic signed [HW-1:0] src_mid   [STAGES];
   logic [TW-1:0]        src_midt  [STAGES];

   logic [RW-1:0]        r_nx  [STAGES];
   logic [OFS_FRAC-1:0]  q_nx  [STAGES];
   logic                 ge_nx [STAGES];

   always_comb begin
      logic nxt;
      nxt = out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || nxt;
         nxt   = en[k];
      end
   end

   assign in_ready = en[0];

   always_comb begin
      src_v[0]     = in_valid;
      src_r[0]     = RW'(in_num);
      src_q[0]     = '0;
      src_dd[0]    = in_dd;
      src_flags[0] = in_flags;
      src_num[0]   = in_num;
      src_smag[0]  = in_smag;
      src_mid[0]   = in_mid;
      src_midt[0]  = in_mid_time;
      for (int k = 1; k < STAGES; k++) begin
         src_v[k]     = v_ff[k-1];
         src_r[k]     = r_ff[k-1];
         src_q[k]     = q_ff[k-1];
         src_dd[k]    = dd_ff[k-1];
         src_flags[k] = flags_ff[k-1];
         src_num[k]   = num_ff[k-1];
         src_smag[k]  = smag_ff[k-1];
         src_mid[k]   = mid_ff[k-1];
         src_midt[k]  = midt_ff[k-1];
      end
   end

   // DIV_STEPS restoring steps per stage; remainder stays below dd while num is below dd
   always_comb begin
      logic [RW-1:0]       r_w;
      logic [OFS_FRAC-1:0] q_w;
      for (int k = 0; k < STAGES; k++) begin
         r_w = src_r[k];
         q_w = src_q[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            r_w = r_w << 1;
            q_w = q_w << 1;
            if (r_w >= src_dd[k]) begin
               r_w    = r_w - src_dd[k];
               q_w[0] = 1'b1;
            end
         end
         r_nx[k] = r_w;
         q_nx[k] = q_w;
      end
      // ratio of one or more saturates the offset
      ge_nx[0] = (RW'(in_num) >= in_dd);
      for (int k = 1; k < STAGES; k++) begin
         ge_nx[k] = ge_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= src_v[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (en[k]) begin
            r_ff[k]     <= r_nx[k];
            q_ff[k]     <= q_nx[k];
            dd_ff[k]    <= src_dd[k];
            ge_ff[k]    <= ge_nx[k];
            flags_ff[k] <= src_flags[k];
            num_ff[k]   <= src_num[k];
            smag_ff[k]  <= src_smag[k];
            mid_ff[k]   <= src_mid[k];
            midt_ff[k]  <= src_midt[k];
         end
      end
   end

   assign out_valid    = v_ff[STAGES-1];
   assign out_flags    = flags_ff[STAGES-1];
   assign out_q        = q_ff[STAGES-1];
   assign out_ge       = ge_ff[STAGES-1];
   assign out_num      = num_ff[STAGES-1];
   assign out_smag     = smag_ff[STAGES-1];
   assign out_mid      = mid_ff[STAGES-1];
   assign out_mid_time = midt_ff[STAGES-1];

endmodule

// ===== rtl/core/ted_refine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_refine
// Applies the offset: scales time step and height difference by the offset,
// adds to the middle sample, saturates the height, holds the result.
// ----------------------------------------------------------------------------
module ted_refine import ted_pkg::*; #(
   parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
   parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  ted_flags_type                  in_flags,
   input  logic [OFS_FRAC-1:0]            in_q,
   input  logic                           in_ge,
   input  logic [HEIGHT_WIDTH:0]          in_num,
   input  logic [TIME_WIDTH-1:0]          in_smag,
   input  logic signed [HEIGHT_WIDTH-1:0] in_mid,
   input  logic [TIME_WIDTH-1:0]          in_mid_time,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_kind,
   output logic [TIME_WIDTH-1:0]          out_time,
   output logic signed [HEIGHT_WIDTH-1:0] out_height
);

   localparam int TW  = TIME_WIDTH;
   localparam int HW  = HEIGHT_WIDTH;
   localparam int QW  = OFS_FRAC + 1;
   localparam int THW = TIME_WIDTH - OFS_FRAC;
   localparam int HHW = HEIGHT_WIDTH + 1 - OFS_FRAC;
   localparam logic [QW-1:0] Q_ONE = QW'(1) << OFS_FRAC;

   // stage 0: partial products
   logic                 v0_ff, en0;
   logic [QW-1:0]        qf;
   logic                 off_neg;
   logic [TW:0]          pt_hi_full;
   logic [2*OFS_FRAC:0]  pt_lo_full, ph_lo_full;
   logic [HW+1:0]        ph_hi_full;
   logic [TW-1:0]        pt_hi_ff;
   logic [QW-1:0]        pt_lo_ff;
   logic [HW:0]          ph_hi_ff;
   logic [QW-1:0]        ph_lo_ff;
   logic                 kind0_ff, tsub0_ff, hadd0_ff;
   logic signed [HW-1:0] mid0_ff;
   logic [TW-1:0]        midt0_ff;

   // stage 1: combined shift products
   logic                 v1_ff, en1;
   logic [HW:0]          corr_sum;
   logic [TW-1:0]        ts1_ff;
   logic [HW-2:0]        corr1_ff;
   logic                 kind1_ff, tsub1_ff, hadd1_ff;
   logic signed [HW-1:0] mid1_ff;
   logic [TW-1:0]        midt1_ff;

   // stage 2: result register
   logic                 v2_ff, en2;
   logic signed [HW+1:0] h_wide;
   logic signed [HW-1:0] h_sat;
   logic                 kind2_ff;
   logic [TW-1:0]        time2_ff;
   logic signed [HW-1:0] height2_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign en0      = !v0_ff || en1;
   assign in_ready = en0;

   always_comb begin
      if (!in_flags.refine) begin
         qf = '0;
      end else if (in_ge) begin
         qf = Q_ONE;
      end else begin
         qf = QW'(in_q);
      end
      off_neg    = (qf != '0) && in_flags.sign_x;
      pt_hi_full = (TW+1)'(in_smag[TW-1:OFS_FRAC]) * (TW+1)'(qf);
      pt_lo_full = (2*OFS_FRAC+1)'(in_smag[OFS_FRAC-1:0]) * (2*OFS_FRAC+1)'(qf);
      ph_hi_full = (HW+2)'(in_num[HW:OFS_FRAC]) * (HW+2)'(qf);
      ph_lo_full = (2*OFS_FRAC+1)'(in_num[OFS_FRAC-1:0]) * (2*OFS_FRAC+1)'(qf);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en0) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         pt_hi_ff <= pt_hi_full[TW-1:0];
         pt_lo_ff <= pt_lo_full[2*OFS_FRAC:OFS_FRAC];
         ph_hi_ff <= ph_hi_full[HW:0];
         ph_lo_ff <= ph_lo_full[2*OFS_FRAC:OFS_FRAC];
         kind0_ff <= in_flags.kind;
         tsub0_ff <= in_flags.step_neg ^ off_neg;
         hadd0_ff <= in_flags.diff_neg ^ off_neg;
         mid0_ff  <= in_mid;
         midt0_ff <= in_mid_time;
      end
   end

   // height correction is the product shifted two more places (factor 0.25)
   assign corr_sum = ph_hi_ff + (HW+1)'(ph_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ts1_ff   <= pt_hi_ff + TW'(pt_lo_ff);
         corr1_ff <= corr_sum[HW:2];
         kind1_ff <= kind0_ff;
         tsub1_ff <= tsub0_ff;
         hadd1_ff <= hadd0_ff;
         mid1_ff  <= mid0_ff;
         midt1_ff <= midt0_ff;
      end
   end

   always_comb begin
      if (hadd1_ff) begin
         h_wide = {{2{mid1_ff[HW-1]}}, mid1_ff} + {3'b000, corr1_ff};
      end else begin
         h_wide = {{2{mid1_ff[HW-1]}}, mid1_ff} - {3'b000, corr1_ff};
      end
      if (h_wide[HW+1:HW-1] == '0 || h_wide[HW+1:HW-1] == '1) begin
         h_sat = h_wide[HW-1:0];
      end else if (h_wide[HW+1]) begin
         h_sat = {1'b1, {(HW-1){1'b0}}};
      end else begin
         h_sat = {1'b0, {(HW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         kind2_ff   <= kind1_ff;
         time2_ff   <= tsub1_ff ? (midt1_ff - ts1_ff) : (midt1_ff + ts1_ff);
         height2_ff <= h_sat;
      end
   end

   assign out_valid  = v2_ff;
   assign out_kind   = kind2_ff;
   assign out_time   = time2_ff;
   assign out_height = height2_ff;

endmodule

// ===== rtl/core/tide_extremum_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tide_extremum_detector_unit
// Detects high and low water in a stream of timed height samples and refines
// each event by three-point parabolic interpolation.
// ----------------------------------------------------------------------------
// Takes one sample per clock unless back-pressure holds it, and reports an
// event for the sample that completes the three-sample window. The event
// passes through window compare and operand setup, the pipelined offset
// divider (two quotient bits per stage, 16 fraction bits), then multiply,
// combine and saturate ending in the output register. A sample that yields
// no event leaves no transaction on rsp. Every stage holds under back-pressure
// and empty stages fill, so req_tready only drops when rsp_tready is low and
// all stages hold data.
module tide_extremum_detector_unit import ted_pkg::*; #(
   parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
   parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [TIME_WIDTH-1:0] sample_time, next HEIGHT_WIDTH bits sample_height, zero pad
   input  logic [((TIME_WIDTH+HEIGHT_WIDTH+7)/8)*8-1:0] req_tdata,
   // [0] curve_start
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [TIME_WIDTH-1:0] refined time, next HEIGHT_WIDTH bits refined height, zero pad
   output logic [((TIME_WIDTH+HEIGHT_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // [0] event_kind
   output logic                  rsp_tuser
);

   localparam int TW         = TIME_WIDTH;
   localparam int HW         = HEIGHT_WIDTH;
   localparam int RSP_DATA_W = ((TIME_WIDTH + HEIGHT_WIDTH + 7) / 8) * 8;

   logic                 w_valid, w_ready;
   ted_flags_type        w_flags;
   logic [HW:0]          w_num;
   logic [HW+2:0]        w_dd;
   logic [TW-1:0]        w_smag, w_mid_time;
   logic signed [HW-1:0] w_mid;

   logic                 d_valid, d_ready, d_ge;
   ted_flags_type        d_flags;
   logic [OFS_FRAC-1:0]  d_q;
   logic [HW:0]          d_num;
   logic [TW-1:0]        d_smag, d_mid_time;
   logic signed [HW-1:0] d_mid;

   logic [TW-1:0]        ev_time;
   logic signed [HW-1:0] ev_height;

   ted_window #(
      .TIME_WIDTH   (TW),
      .HEIGHT_WIDTH (HW)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_time      (req_tdata[TW-1:0]),
      .in_height    (req_tdata[TW+HW-1:TW]),
      .in_start     (req_tuser),
      .out_valid    (w_valid),
      .out_ready    (w_ready),
      .out_flags    (w_flags),
      .out_num      (w_num),
      .out_dd       (w_dd),
      .out_smag     (w_smag),
      .out_mid      (w_mid),
      .out_mid_time (w_mid_time)
   );

   ted_divider #(
      .TIME_WIDTH   (TW),
      .HEIGHT_WIDTH (HW)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (w_valid),
      .in_ready     (w_ready),
      .in_flags     (w_flags),
      .in_num       (w_num),
      .in_dd        (w_dd),
      .in_smag      (w_smag),
      .in_mid       (w_mid),
      .in_mid_time  (w_mid_time),
      .out_valid    (d_valid),
      .out_ready    (d_ready),
      .out_flags    (d_flags),
      .out_q        (d_q),
      .out_ge       (d_ge),
      .out_num      (d_num),
      .out_smag     (d_smag),
      .out_mid      (d_mid),
      .out_mid_time (d_mid_time)
   );

   ted_refine #(
      .TIME_WIDTH   (TW),
      .HEIGHT_WIDTH (HW)
   ) u_refine (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_valid),
      .in_ready    (d_ready),
      .in_flags    (d_flags),
      .in_q        (d_q),
      .in_ge       (d_ge),
      .in_num      (d_num),
      .in_smag     (d_smag),
      .in_mid      (d_mid),
      .in_mid_time (d_mid_time),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (rsp_tuser),
      .out_time    (ev_time),
      .out_height  (ev_height)
   );

   assign rsp_tdata = RSP_DATA_W'({ev_height, ev_time});

endmodule

// ===== rtl/core/ted_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_checker
// Port-level checks of the tide extremum detector, bound to the top level.
// ----------------------------------------------------------------------------
module ted_checker import ted_pkg::*; #(
   parameter int DATA_W = ((TIME_WIDTH_DEF + HEIGHT_WIDTH_DEF + 7) / 8) * 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tuser
);

   // a stalled result transaction holds
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=>
            rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("rsp transaction changed while stalled");

   // reset empties the pipeline
   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_tvalid;
   endproperty
   a_reset_empty: assert property (p_reset_empty)
      else $error("result valid right after reset");

   // with the output free, every stage can advance, so input is taken
   property p_ready_when_free;
      @(posedge clock) (!rsp_tvalid || rsp_tready) |-> req_tready;
   endproperty
   a_ready_when_free: assert property (p_ready_when_free)
      else $error("input stalled although output is free");

endmodule

bind tide_extremum_detector_unit ted_checker #(
   .DATA_W (RSP_DATA_W)
) u_ted_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
